// ----- rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: types and constants of the period to speed filter
// Payload structs, register indexes, widths and the sequencer states.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Filter and field widths
	localparam int FILTER_SHIFT = 8;
	localparam int ACC_W        = 32;
	localparam int SHIFTED_W    = ACC_W - FILTER_SHIFT;
	localparam int PERIOD_W     = 16;
	localparam int SPEED_W      = 10;
	localparam int SLEW_W       = 16;
	localparam int SCALE_W      = 22;
	localparam int CFG_IDX_W    = 2;

	// Divider: one quotient bit per step
	localparam int DIV_STEPS = SCALE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1874572);
	localparam logic [SPEED_W-1:0] LIMIT_RESET = SPEED_W'(540);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [PERIOD_W-1:0] pulse_period;
		logic                no_pulse;
		logic                clear_peak;
	} pts_in_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_out;
		logic [SPEED_W-1:0] peak_out;
	} pts_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SLEW,
		ST_ACCUM,
		ST_SHOW
	} pts_state_t;

endpackage

// ----- rtl/period_to_speed_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// period_to_speed_filter: pulse period to filtered gauge speed
// Divides the speed scale by the pulse period, slew-limits and low-pass
// filters the result, clamps it and tracks its peak.
// ----------------------------------------------------------------------------
// Each accepted item runs through the restoring divider, one step per cycle
// for the 22 quotient bits of speed_scale / pulse_period, then through the
// slew step, the accumulator update and the clamp with peak tracking, whose
// result is registered. The block then returns to idle; it takes no new item
// before it is through with the last one. in_ready is high only
// while the block is idle; a result waits in the output register, and the
// next item is accepted while it waits. If that earlier result is still
// waiting when the next one reaches the clamp step, the clamp step holds
// until the output register is taken. Configuration writes are always taken
// (cfg_ready is tied high); an index outside the register list is ignored.
// ----------------------------------------------------------------------------
module period_to_speed_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pts_pkg::pts_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pts_pkg::pts_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pts_pkg::SCALE_W-1:0]    cfg_data
);
	import pts_pkg::*;

	pts_state_t state_q, state_d;

	// Configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [SPEED_W-1:0] limit_q;

	// Filter state
	logic [SLEW_W-1:0]  slew_q;
	logic [ACC_W-1:0]   acc_q;
	logic [SPEED_W-1:0] shown_q;
	logic [SPEED_W-1:0] peak_q;

	// Divider working registers
	logic [PERIOD_W-1:0] div_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [SCALE_W-1:0]  quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                zero_q;
	logic                clear_q;

	// Output register
	logic     out_valid_q;
	pts_out_t out_data_q;

	// Sequencer controls
	logic accept;
	logic div_last;
	logic commit;
	logic do_div;
	logic do_slew;
	logic do_accum;

	// Datapath signals
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                ge;
	logic [SLEW_W-1:0]   raw;
	logic [SLEW_W-1:0]   slew_d;
	logic [SHIFTED_W-1:0] shifted;
	logic [SPEED_W-1:0]  shown_d;
	logic [SPEED_W-1:0]  peak_base;
	logic [SPEED_W-1:0]  peak_d;

	assign accept    = in_valid && in_ready;
	assign div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DIVIDE;
			ST_DIVIDE: if (div_last) state_d = ST_SLEW;
			ST_SLEW:   state_d = ST_ACCUM;
			ST_ACCUM:  state_d = ST_SHOW;
			ST_SHOW:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		do_div   = 1'b0;
		do_slew  = 1'b0;
		do_accum = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_DIVIDE: do_div = 1'b1;
			ST_SLEW:   do_slew = 1'b1;
			ST_ACCUM:  do_accum = 1'b1;
			ST_SHOW:   commit = !out_valid_q || out_ready;
			default:   in_ready = 1'b0;
		endcase
	end

	// Restoring divider step
	always_comb begin
		trial = {rem_q, quo_q[SCALE_W-1]};
		ge    = (trial >= {1'b0, div_q});
		diff  = trial - {1'b0, div_q};
	end

	// Raw speed with saturation, then one slew step
	always_comb begin
		if (zero_q) begin
			raw = '0;
		end else if (|quo_q[SCALE_W-1:SLEW_W]) begin
			raw = '1;
		end else begin
			raw = quo_q[SLEW_W-1:0];
		end
		if (raw > slew_q) begin
			slew_d = slew_q + SLEW_W'(1);
		end else if (raw < slew_q) begin
			slew_d = slew_q - SLEW_W'(1);
		end else begin
			slew_d = slew_q;
		end
	end

	// Clamp and peak
	always_comb begin
		shifted = acc_q[ACC_W-1:FILTER_SHIFT];
		if (shifted > SHIFTED_W'(limit_q)) begin
			shown_d = limit_q;
		end else begin
			shown_d = shifted[SPEED_W-1:0];
		end
		peak_base = clear_q ? '0 : peak_q;
		peak_d    = (shown_d > peak_base) ? shown_d : peak_base;
	end

	// Control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			scale_q     <= SCALE_RESET;
			limit_q     <= LIMIT_RESET;
			slew_q      <= '0;
			acc_q       <= '0;
			shown_q     <= '0;
			peak_q      <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (do_div) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SPEED_SCALE: scale_q <= cfg_data;
					REG_SPEED_LIMIT: limit_q <= cfg_data[SPEED_W-1:0];
					default:         ;
				endcase
			end
			if (do_slew) begin
				slew_q <= slew_d;
			end
			if (do_accum) begin
				acc_q <= acc_q + ACC_W'(slew_q) - ACC_W'(shown_q);
			end
			if (commit) begin
				shown_q     <= shown_d;
				peak_q      <= peak_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			div_q   <= in_data.pulse_period;
			rem_q   <= '0;
			quo_q   <= scale_q;
			zero_q  <= in_data.no_pulse || (in_data.pulse_period == '0);
			clear_q <= in_data.clear_peak;
		end else if (do_div) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[SCALE_W-2:0], ge};
		end
		if (commit) begin
			out_data_q.speed_out <= shown_d;
			out_data_q.peak_out  <= peak_d;
		end
	end

	// An accepted item starts the divider at its first step
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIVIDE) && (cnt_q == '0))
		else $error("divider did not start after accept");

	// The step counter stays within the quotient width
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)))
		else $error("divider step count out of range");

	// The slew value moves at most one step per item
	a_slew_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLEW) |=> ((slew_q == $past(slew_q)) ||
			(slew_q == $past(slew_q) + SLEW_W'(1)) ||
			(slew_q == $past(slew_q) - SLEW_W'(1))))
		else $error("slew step larger than one");

	// The peak shown never lies below the speed shown with it
	a_peak_ge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.peak_out >= out_data_q.speed_out))
		else $error("peak below shown speed");

	// A result is only written while the output register is free or drains
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(out_data_q))
		else $error("pending result overwritten");

endmodule
